// ===== hdl/char_lcd_write_sequencer_macros.svh =====
// Assertion helpers shared by the sequencer RTL.
// Each macro expects clk and rst_n in the calling scope.
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CLWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");
// next-cycle implication
`define CLWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");
`else
`define CLWS_ASSERT_IMPL(lbl, ante, cons)
`define CLWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/clws_pkg.sv =====
`timescale 1ns / 1ps

package clws_pkg;

  localparam int TICK_W = 17;
  localparam int WORD_W = 11;

  // operation codes
  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_CMD   = 3'd0;
  localparam opcode_t OP_DATA  = 3'd1;
  localparam opcode_t OP_CLEAR = 3'd2;
  localparam opcode_t OP_DEC3  = 3'd3;
  localparam opcode_t OP_INIT  = 3'd4;
  localparam opcode_t OP_GLYPH = 3'd5;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SETUP       = 3'd0;
  localparam cfg_idx_t CFG_STROBE      = 3'd1;
  localparam cfg_idx_t CFG_CMD_SETTLE  = 3'd2;
  localparam cfg_idx_t CFG_DATA_SETTLE = 3'd3;
  localparam cfg_idx_t CFG_POWER_UP    = 3'd4;
  localparam cfg_idx_t CFG_INIT_TAIL   = 3'd5;

  typedef logic [TICK_W-1:0] tick_t;
  localparam tick_t RST_SETUP       = 17'd1;
  localparam tick_t RST_STROBE      = 17'd2;
  localparam tick_t RST_CMD_SETTLE  = 17'd11389;
  localparam tick_t RST_DATA_SETTLE = 17'd278;
  localparam tick_t RST_POWER_UP    = 17'd104167;
  localparam tick_t RST_INIT_TAIL   = 17'd10417;

  // LCD command and character codes
  localparam logic [7:0] LCD_FUNC_SET = 8'h38;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0c;
  localparam logic [7:0] LCD_ERASE    = 8'h01;
  localparam logic [7:0] LCD_CGRAM    = 8'h40;
  localparam logic [7:0] LCD_DDRAM    = 8'h80;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  // decimal conversion steps
  localparam logic [2:0] CV_QUOT = 3'd0;  // value / 1000 estimate
  localparam logic [2:0] CV_MOD  = 3'd1;  // value mod 1000
  localparam logic [2:0] CV_HUND = 3'd2;  // hundreds digit
  localparam logic [2:0] CV_HREM = 3'd3;  // strip hundreds
  localparam logic [2:0] CV_TENS = 3'd4;  // tens digit
  localparam logic [2:0] CV_TREM = 3'd5;  // strip tens, units remain
  localparam logic [2:0] CV_DONE = 3'd6;

  // reciprocal multipliers: x*67109>>26 = x/1000 for 16-bit x,
  // x*41>>12 = x/100 for x < 1000, x*205>>11 = x/10 for x < 100
  localparam logic [16:0] RCP_DIV1000 = 17'd67109;
  localparam logic [15:0] RCP_DIV100  = 16'd41;
  localparam logic [15:0] RCP_DIV10   = 16'd205;
  localparam logic [15:0] DEC_1000    = 16'd1000;
  localparam logic [15:0] DEC_100     = 16'd100;
  localparam logic [15:0] DEC_10      = 16'd10;

  // queue sizing
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified operation, as the back end consumes it
  typedef struct packed {
    opcode_t     op;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [2:0]  slot;
    logic [55:0] rows;
  } job_t;

  typedef struct packed {
    tick_t setup;
    tick_t strobe;
    tick_t cmd_settle;
    tick_t data_settle;
    tick_t power_up;
    tick_t init_tail;
  } cfg_t;

  // number of bus writes an operation expands into
  function automatic logic [3:0] job_writes(input opcode_t op);
    logic [3:0] n;
    n = 4'd0;
    unique case (op)
      OP_CMD, OP_DATA, OP_CLEAR: n = 4'd1;
      OP_DEC3:                   n = 4'd3;
      OP_INIT:                   n = 4'd4;
      OP_GLYPH:                  n = 4'd11;
      default:                   n = 4'd0;
    endcase
    return n;
  endfunction

  // {rs, byte} of bus write w of a job
  function automatic logic [8:0] job_byte(input job_t j, input logic [3:0] w);
    logic [8:0] r;
    r = 9'd0;
    unique case (j.op)
      OP_CMD:   r = {1'b0, j.b0};
      OP_DATA:  r = {1'b1, j.b0};
      OP_CLEAR: r = {1'b0, LCD_ERASE};
      OP_DEC3: begin
        unique case (w)
          4'd0:    r = {1'b1, j.b0};
          4'd1:    r = {1'b1, j.b1};
          default: r = {1'b1, j.b2};
        endcase
      end
      OP_INIT: begin
        unique case (w)
          4'd0:    r = {1'b0, LCD_FUNC_SET};
          4'd1:    r = {1'b0, LCD_ENTRY};
          4'd2:    r = {1'b0, LCD_DISP_ON};
          default: r = {1'b0, LCD_ERASE};
        endcase
      end
      OP_GLYPH: begin
        unique case (w)
          4'd0:    r = {1'b0, LCD_CGRAM | {2'b00, j.slot, 3'b000}};
          4'd1:    r = {1'b1, j.rows[7:0]};
          4'd2:    r = {1'b1, j.rows[15:8]};
          4'd3:    r = {1'b1, j.rows[23:16]};
          4'd4:    r = {1'b1, j.rows[31:24]};
          4'd5:    r = {1'b1, j.rows[39:32]};
          4'd6:    r = {1'b1, j.rows[47:40]};
          4'd7:    r = {1'b1, j.rows[55:48]};
          4'd8:    r = {1'b1, 8'h00};
          4'd9:    r = {1'b0, LCD_DDRAM};
          default: r = {1'b1, 5'b00000, j.slot};
        endcase
      end
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/clws_front.sv =====
`timescale 1ns / 1ps

module clws_front import clws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  opcode_t     in_opcode,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  input  logic [2:0]  in_glyph_slot,
  input  logic [55:0] in_glyph_rows,
  output logic        push_valid,
  output job_t        push_job,
  input  logic        q_full
);

  logic        conv_r, conv_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [6:0]  quo_r, quo_nxt;
  logic [3:0]  hund_r, hund_nxt;
  logic [3:0]  tens_r, tens_nxt;
  logic        lt100_r, lt100_nxt;
  logic        lt10_r, lt10_nxt;

  logic        in_acc;
  logic        is_dec;
  logic        op_ok;
  logic [32:0] prod_q;
  logic [15:0] quo_k;
  logic [15:0] prod_h;
  logic [15:0] hund_k;
  logic [15:0] prod_t;
  logic [15:0] tens_k;

  assign in_stall = conv_r || q_full;
  assign in_acc   = in_valid && !in_stall;
  assign is_dec   = in_opcode == OP_DEC3;
  assign op_ok    = in_opcode <= OP_GLYPH;

  // one short multiply step per cycle
  assign prod_q = rem_r * RCP_DIV1000;
  assign quo_k  = {9'd0, quo_r} * DEC_1000;
  assign prod_h = {6'd0, rem_r[9:0]} * RCP_DIV100;
  assign hund_k = {12'd0, hund_r} * DEC_100;
  assign prod_t = {9'd0, rem_r[6:0]} * RCP_DIV10;
  assign tens_k = {12'd0, tens_r} * DEC_10;

  // item to the queue: direct for simple ops, after conversion for decimal
  always_comb begin
    push_job = '0;
    if (conv_r) begin
      push_valid  = k_r == CV_DONE;
      push_job.op = OP_DEC3;
      push_job.b0 = lt100_r ? CH_SPACE : (CH_ZERO | {4'b0000, hund_r});
      push_job.b1 = lt10_r ? CH_SPACE : (CH_ZERO | {4'b0000, tens_r});
      push_job.b2 = CH_ZERO | {4'b0000, rem_r[3:0]};
    end else begin
      push_valid    = in_valid && op_ok && !is_dec;
      push_job.op   = in_opcode;
      push_job.b0   = in_byte_value;
      push_job.slot = in_glyph_slot;
      push_job.rows = in_glyph_rows;
    end
  end

  // conversion sequencer
  always_comb begin
    conv_nxt  = conv_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    hund_nxt  = hund_r;
    tens_nxt  = tens_r;
    lt100_nxt = lt100_r;
    lt10_nxt  = lt10_r;
    if (!conv_r) begin
      if (in_acc && is_dec) begin
        conv_nxt  = 1'b1;
        k_nxt     = CV_QUOT;
        rem_nxt   = in_number;
        quo_nxt   = 7'd0;
        hund_nxt  = 4'd0;
        tens_nxt  = 4'd0;
        lt100_nxt = in_number < 16'd100;
        lt10_nxt  = in_number < 16'd10;
      end
    end else if (k_r != CV_DONE) begin
      k_nxt = k_r + 3'd1;
      unique case (k_r)
        CV_QUOT: quo_nxt  = prod_q[32:26];
        CV_MOD:  rem_nxt  = rem_r - quo_k;
        CV_HUND: hund_nxt = prod_h[15:12];
        CV_HREM: rem_nxt  = rem_r - hund_k;
        CV_TENS: tens_nxt = prod_t[14:11];
        CV_TREM: rem_nxt  = rem_r - tens_k;
        default: ;
      endcase
    end else if (!q_full) begin
      conv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
      k_r    <= CV_QUOT;
    end else begin
      conv_r <= conv_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    hund_r  <= hund_nxt;
    tens_r  <= tens_nxt;
    lt100_r <= lt100_nxt;
    lt10_r  <= lt10_nxt;
  end

endmodule

// ===== hdl/clws_queue.sv =====
`timescale 1ns / 1ps

module clws_queue import clws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_fire;
  logic              pop_fire;

  assign full      = cnt_r == QCNT_W'(QDEPTH);
  assign empty     = cnt_r == '0;
  assign push_fire = push_valid && !full;
  assign pop_fire  = pop && !empty;
  assign pop_job   = mem_r[rd_ptr_r];

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/clws_back.sv =====
`timescale 1ns / 1ps

module clws_back import clws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_port_word,
  output logic              out_write_valid,
  output tick_t             out_hold_ticks,
  output logic              out_last
);

  // sequencer states
  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_PRE  = 2'd1;
  localparam logic [1:0] BK_WR   = 2'd2;
  localparam logic [1:0] BK_TAIL = 2'd3;

  // strobe phases of one bus write
  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;

  logic [1:0]        st_r, st_nxt;
  job_t              job_r, job_nxt;
  logic [3:0]        w_r, w_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [3:0]        nw_r, nw_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              wv_r, wv_nxt;
  tick_t             hold_r, hold_nxt;
  logic              last_r, last_nxt;

  logic              advance;
  logic              emit;
  logic [8:0]        wb;
  logic              wr_last;
  logic              res_last;
  logic [WORD_W-1:0] res_word;
  logic              res_wv;
  tick_t             res_hold;

  assign advance  = !out_valid_r || !out_stall;
  assign emit     = advance && (st_r != BK_IDLE);
  assign wb       = job_byte(job_r, w_r);
  assign wr_last  = (ph_r == PH_SETTLE) && (w_r == nw_r - 4'd1);
  assign res_last = (st_r == BK_TAIL) ||
                    ((st_r == BK_WR) && wr_last && (job_r.op != OP_INIT));
  assign q_pop    = !q_empty && ((st_r == BK_IDLE) || (emit && res_last));

  // current result
  always_comb begin
    res_word = '0;
    res_wv   = 1'b0;
    res_hold = '0;
    unique case (st_r)
      BK_PRE: res_hold = cfg.power_up;
      BK_TAIL: res_hold = cfg.init_tail;
      BK_WR: begin
        res_word = {ph_r == PH_STROBE, wb[8], 1'b0, wb[7:0]};
        res_wv   = 1'b1;
        unique case (ph_r)
          PH_SETUP:  res_hold = cfg.setup;
          PH_STROBE: res_hold = cfg.strobe;
          default:   res_hold = wb[8] ? cfg.data_settle : cfg.cmd_settle;
        endcase
      end
      default: res_hold = '0;
    endcase
  end

  // step through the job; a new job loads as the last result goes out
  always_comb begin
    st_nxt  = st_r;
    job_nxt = job_r;
    w_nxt   = w_r;
    ph_nxt  = ph_r;
    nw_nxt  = nw_r;
    if (emit) begin
      unique case (st_r)
        BK_PRE:  st_nxt = BK_WR;
        BK_TAIL: st_nxt = BK_IDLE;
        BK_WR: begin
          if (ph_r == PH_SETTLE) begin
            ph_nxt = PH_SETUP;
            if (wr_last) begin
              st_nxt = (job_r.op == OP_INIT) ? BK_TAIL : BK_IDLE;
            end else begin
              w_nxt = w_r + 4'd1;
            end
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end
        default: st_nxt = BK_IDLE;
      endcase
    end
    if (q_pop) begin
      job_nxt = q_job;
      w_nxt   = 4'd0;
      ph_nxt  = PH_SETUP;
      nw_nxt  = job_writes(q_job.op);
      st_nxt  = (q_job.op == OP_INIT) ? BK_PRE : BK_WR;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    word_nxt      = word_r;
    wv_nxt        = wv_r;
    hold_nxt      = hold_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = emit;
      word_nxt      = res_word;
      wv_nxt        = res_wv;
      hold_nxt      = res_hold;
      last_nxt      = res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      w_r         <= 4'd0;
      ph_r        <= PH_SETUP;
      nw_r        <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      w_r         <= w_nxt;
      ph_r        <= ph_nxt;
      nw_r        <= nw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    word_r <= word_nxt;
    wv_r   <= wv_nxt;
    hold_r <= hold_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_port_word   = word_r;
  assign out_write_valid = wv_r;
  assign out_hold_ticks  = hold_r;
  assign out_last        = last_r;

endmodule

// ===== hdl/char_lcd_write_sequencer.sv =====
`timescale 1ns / 1ps
`include "char_lcd_write_sequencer_macros.svh"

// Character-LCD write sequencer. Each accepted item with a used opcode is one
// LCD operation that comes out as a run of results, one per clock while
// out_stall is low: a command, data or clear op gives 3 results, decimal3
// gives 9, init gives 14 and glyph load gives 33, the final one flagged by
// out_last; spare opcodes give none. The back-end sequencer emits one result
// per cycle while out_stall is low and starts the next queued operation as
// the last result of the current one goes out. The front end takes a new item
// every cycle while the two-entry queue has room and no decimal3 conversion
// is running; a decimal3 item holds in_stall (longer while the queue is full)
// while a small reciprocal-multiply unit extracts its digits. cfg_ready is always
// high; write timing registers only while the block is idle. Reset is
// synchronous, active low, and restores the default hold counts.
module char_lcd_write_sequencer import clws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_byte_value,
  input  logic [15:0]       in_number,
  input  logic [2:0]        in_glyph_slot,
  input  logic [55:0]       in_glyph_rows,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_port_word,
  output logic              out_write_valid,
  output logic [TICK_W-1:0] out_hold_ticks,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [TICK_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic push_valid;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t q_job;

  // timing registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SETUP:       cfg_nxt.setup       = cfg_data;
        CFG_STROBE:      cfg_nxt.strobe      = cfg_data;
        CFG_CMD_SETTLE:  cfg_nxt.cmd_settle  = cfg_data;
        CFG_DATA_SETTLE: cfg_nxt.data_settle = cfg_data;
        CFG_POWER_UP:    cfg_nxt.power_up    = cfg_data;
        CFG_INIT_TAIL:   cfg_nxt.init_tail   = cfg_data;
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup       <= RST_SETUP;
      cfg_r.strobe      <= RST_STROBE;
      cfg_r.cmd_settle  <= RST_CMD_SETTLE;
      cfg_r.data_settle <= RST_DATA_SETTLE;
      cfg_r.power_up    <= RST_POWER_UP;
      cfg_r.init_tail   <= RST_INIT_TAIL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clws_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .in_glyph_slot (in_glyph_slot),
    .in_glyph_rows (in_glyph_rows),
    .push_valid    (push_valid),
    .push_job      (push_job),
    .q_full        (q_full)
  );

  clws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .pop_job    (q_job)
  );

  clws_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (q_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_port_word   (out_port_word),
    .out_write_valid (out_write_valid),
    .out_hold_ticks  (out_hold_ticks),
    .out_last        (out_last)
  );

  // back end only pops a filled queue
  `CLWS_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty)
  // unused opcodes never reach the queue
  `CLWS_ASSERT_IMPL(a_push_op_legal, push_valid && !q_full, push_job.op <= OP_GLYPH)
  // a pure wait carries an all-zero port word
  `CLWS_ASSERT_IMPL(a_wait_word_zero, out_valid && !out_write_valid, out_port_word == '0)
  // an accepted decimal item occupies the converter
  `CLWS_ASSERT_NEXT(a_dec_stalls, in_valid && !in_stall && in_opcode == OP_DEC3, in_stall)

endmodule

// ===== test/lcd_sequence_checker.sv =====
`timescale 1ns / 1ps

// Watches the operation, result and timing-register channels of the LCD write
// sequencer, expands every accepted operation into its expected port writes
// and waits, and compares each accepted result against the oldest expected step.
module lcd_sequence_checker import clws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_byte_value,
  input  logic [15:0]       in_number,
  input  logic [2:0]        in_glyph_slot,
  input  logic [55:0]       in_glyph_rows,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [WORD_W-1:0] out_port_word,
  input  logic              out_write_valid,
  input  logic [TICK_W-1:0] out_hold_ticks,
  input  logic              out_last,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [TICK_W-1:0] cfg_data,
  output int                fail_count,
  output int                outstanding
);

  localparam logic [WORD_W-1:0] PORT_E  = 11'h400;
  localparam logic [WORD_W-1:0] PORT_RS = 11'h200;
  localparam logic [7:0]        GLYPH_PAD_ROW = 8'h00;

  // one port write or pure wait
  typedef struct packed {
    logic [WORD_W-1:0] port_word;
    logic              write_valid;
    tick_t             hold_ticks;
    logic              last;
  } lcd_step_t;

  lcd_step_t expected_steps[$];
  cfg_t      timing;

  task automatic add_step(input logic [WORD_W-1:0] word, input logic wr, input tick_t hold);
    lcd_step_t s;
    s.port_word   = word;
    s.write_valid = wr;
    s.hold_ticks  = hold;
    s.last        = 1'b0;
    expected_steps.push_back(s);
  endtask

  // E low, E high, E low; settle time depends on RS
  task automatic add_bus_write(input logic [7:0] value, input logic is_data);
    logic [WORD_W-1:0] low;
    low = {3'b000, value} | (is_data ? PORT_RS : '0);
    add_step(low, 1'b1, timing.setup);
    add_step(low | PORT_E, 1'b1, timing.strobe);
    add_step(low, 1'b1, is_data ? timing.data_settle : timing.cmd_settle);
  endtask

  task automatic expand_operation(input opcode_t op, input logic [7:0] value,
                                  input logic [15:0] num, input logic [2:0] slot,
                                  input logic [55:0] rows);
    int unsigned before_count;
    int unsigned rem;
    int          row;
    logic [7:0]  hund;
    logic [7:0]  tens;
    logic [7:0]  ones;
    before_count = expected_steps.size();
    rem = num % 1000;
    case (op)
      OP_CMD:   add_bus_write(value, 1'b0);
      OP_DATA:  add_bus_write(value, 1'b1);
      OP_CLEAR: add_bus_write(LCD_ERASE, 1'b0);
      OP_DEC3: begin
        // leading blanks go by the full value, digits by value mod 1000
        hund = (num < 100) ? CH_SPACE : CH_ZERO + 8'(rem / 100);
        tens = (num < 10) ? CH_SPACE : CH_ZERO + 8'((rem % 100) / 10);
        ones = CH_ZERO + 8'(rem % 10);
        add_bus_write(hund, 1'b1);
        add_bus_write(tens, 1'b1);
        add_bus_write(ones, 1'b1);
      end
      OP_INIT: begin
        add_step('0, 1'b0, timing.power_up);
        add_bus_write(LCD_FUNC_SET, 1'b0);
        add_bus_write(LCD_ENTRY, 1'b0);
        add_bus_write(LCD_DISP_ON, 1'b0);
        add_bus_write(LCD_ERASE, 1'b0);
        add_step('0, 1'b0, timing.init_tail);
      end
      OP_GLYPH: begin
        add_bus_write(LCD_CGRAM | {2'b00, slot, 3'b000}, 1'b0);
        for (row = 0; row < 7; row++) add_bus_write(rows[8*row +: 8], 1'b1);
        add_bus_write(GLYPH_PAD_ROW, 1'b1);
        add_bus_write(LCD_DDRAM, 1'b0);
        add_bus_write({5'b00000, slot}, 1'b1);
      end
      default: ;  // spare opcodes make nothing
    endcase
    if (expected_steps.size() > before_count)
      expected_steps[expected_steps.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    lcd_step_t want;
    if (!rst_n) begin
      expected_steps.delete();
      fail_count         = 0;
      timing.setup       = RST_SETUP;
      timing.strobe      = RST_STROBE;
      timing.cmd_settle  = RST_CMD_SETTLE;
      timing.data_settle = RST_DATA_SETTLE;
      timing.power_up    = RST_POWER_UP;
      timing.init_tail   = RST_INIT_TAIL;
    end else begin
      // timing register writes; unused indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SETUP:       timing.setup       = cfg_data;
          CFG_STROBE:      timing.strobe      = cfg_data;
          CFG_CMD_SETTLE:  timing.cmd_settle  = cfg_data;
          CFG_DATA_SETTLE: timing.data_settle = cfg_data;
          CFG_POWER_UP:    timing.power_up    = cfg_data;
          CFG_INIT_TAIL:   timing.init_tail   = cfg_data;
          default: ;
        endcase
      end

      // result check
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected result: port_word %h hold_ticks %0d", out_port_word,
                 out_hold_ticks);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          if (out_port_word !== want.port_word) begin
            $error("port_word: expected %h, actual %h", want.port_word, out_port_word);
            fail_count++;
          end
          if (out_write_valid !== want.write_valid) begin
            $error("write_valid: expected %b, actual %b", want.write_valid,
                   out_write_valid);
            fail_count++;
          end
          if (out_hold_ticks !== want.hold_ticks) begin
            $error("hold_ticks: expected %0d, actual %0d", want.hold_ticks,
                   out_hold_ticks);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_last);
            fail_count++;
          end
        end
      end

      // new operation
      if (in_valid && !in_stall)
        expand_operation(in_opcode, in_byte_value, in_number, in_glyph_slot, in_glyph_rows);
    end
    outstanding <= expected_steps.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import clws_pkg::*;

  localparam opcode_t  OP_SPARE_A    = 3'd6;
  localparam opcode_t  OP_SPARE_B    = 3'd7;
  localparam cfg_idx_t CFG_UNUSED_LO = 3'd6;
  localparam cfg_idx_t CFG_UNUSED_HI = 3'd7;
  localparam tick_t    TICK_MAX      = 17'h1ffff;
  localparam int       SETTLE_CYCLES = 48;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_opcode;
  logic [7:0]        in_byte_value;
  logic [15:0]       in_number;
  logic [2:0]        in_glyph_slot;
  logic [55:0]       in_glyph_rows;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_port_word;
  logic              out_write_valid;
  logic [TICK_W-1:0] out_hold_ticks;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [TICK_W-1:0] cfg_data;
  int                fail_count;
  int                outstanding;
  bit                steady = 1'b0;  // no idling on either side while set

  char_lcd_write_sequencer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_byte_value   (in_byte_value),
    .in_number       (in_number),
    .in_glyph_slot   (in_glyph_slot),
    .in_glyph_rows   (in_glyph_rows),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_port_word   (out_port_word),
    .out_write_valid (out_write_valid),
    .out_hold_ticks  (out_hold_ticks),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lcd_sequence_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_byte_value   (in_byte_value),
    .in_number       (in_number),
    .in_glyph_slot   (in_glyph_slot),
    .in_glyph_rows   (in_glyph_rows),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_port_word   (out_port_word),
    .out_write_valid (out_write_valid),
    .out_hold_ticks  (out_hold_ticks),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("char_lcd_write_sequencer: mismatch");
    $finish;
  end

  // result side: random stall before each result
  initial begin : result_sink
    int unsigned hold_off;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold_off = steady ? 0 : $urandom_range(0, 8);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [55:0] rand_rows();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  // bias toward the blanking and mod-1000 boundaries
  function automatic logic [15:0] rand_number();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 12));
      1:       return 16'($urandom_range(95, 105));
      2:       return 16'($urandom_range(990, 1010));
      default: return 16'($urandom);
    endcase
  endfunction

  // one item; valid stays high on return
  task automatic send_op(input opcode_t op, input logic [7:0] value, input logic [15:0] num,
                         input logic [2:0] slot, input logic [55:0] rows);
    int unsigned pause;
    pause = steady ? 0 : $urandom_range(0, 8);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_byte_value <= value;
    in_number     <= num;
    in_glyph_slot <= slot;
    in_glyph_rows <= rows;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every expected result is out, then let the block go idle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input tick_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all six timing registers, with writes to unused indexes mixed in
  task automatic load_timing(input tick_t t_setup, input tick_t t_strobe, input tick_t t_cmd,
                             input tick_t t_data, input tick_t t_power, input tick_t t_tail);
    cfg_put(CFG_SETUP, t_setup);
    cfg_put(CFG_UNUSED_LO, tick_t'($urandom));
    cfg_put(CFG_STROBE, t_strobe);
    cfg_put(CFG_CMD_SETTLE, t_cmd);
    cfg_put(CFG_DATA_SETTLE, t_data);
    cfg_put(CFG_POWER_UP, t_power);
    cfg_put(CFG_INIT_TAIL, t_tail);
    cfg_put(CFG_UNUSED_HI, TICK_MAX);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_timing();
    load_timing(tick_t'($urandom), tick_t'($urandom), tick_t'($urandom),
                tick_t'($urandom), tick_t'($urandom), tick_t'($urandom));
  endtask

  // random operations; spare opcodes do not count toward the quota
  task automatic random_ops(input int unsigned quota);
    int unsigned counted;
    int unsigned pick;
    opcode_t     op;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
      else if (pick < 20) op = OP_CMD;
      else if (pick < 36) op = OP_DATA;
      else if (pick < 46) op = OP_CLEAR;
      else if (pick < 70) op = OP_DEC3;
      else if (pick < 78) op = OP_INIT;
      else                op = OP_GLYPH;
      if (op != OP_SPARE_A && op != OP_SPARE_B) counted++;
      send_op(op, 8'($urandom), rand_number(), 3'($urandom), rand_rows());
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_CMD;
    in_byte_value <= '0;
    in_number     <= '0;
    in_glyph_slot <= '0;
    in_glyph_rows <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_SETUP;
    cfg_data      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass on reset timing
    send_op(OP_CMD, 8'h00, 16'h0000, 3'd0, '0);
    send_op(OP_CMD, 8'hff, 16'hffff, 3'd7, '1);
    send_op(OP_DATA, 8'h00, 16'hffff, 3'd7, '1);
    send_op(OP_DATA, 8'hff, 16'h0000, 3'd0, '0);
    send_op(OP_CLEAR, 8'ha5, 16'h5a5a, 3'd5, rand_rows());
    send_op(OP_DEC3, 8'hff, 16'd0, 3'd7, '1);
    send_op(OP_DEC3, 8'h00, 16'd9, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd10, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd99, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd100, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd999, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd1000, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd1009, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd12345, 3'd0, '0);
    send_op(OP_DEC3, 8'h00, 16'd65535, 3'd0, '0);
    send_op(OP_INIT, 8'h3c, 16'd777, 3'd2, rand_rows());
    send_op(OP_GLYPH, 8'h00, 16'd0, 3'd0, '0);
    send_op(OP_GLYPH, 8'hff, 16'hffff, 3'd7, '1);
    send_op(OP_GLYPH, 8'($urandom), 16'($urandom), 3'd3, rand_rows());
    send_op(OP_SPARE_A, 8'hff, 16'hffff, 3'd7, '1);
    send_op(OP_SPARE_B, 8'h00, 16'h0000, 3'd0, '0);
    send_op(OP_DATA, 8'h5a, 16'd42, 3'd1, rand_rows());

    // widest holds
    drain_results();
    load_timing(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
    random_ops(30);

    // zero holds, back-to-back traffic on both sides
    drain_results();
    load_timing('0, '0, '0, '0, '0, '0);
    steady = 1'b1;
    random_ops(30);
    steady = 1'b0;

    drain_results();
    load_random_timing();
    random_ops(35);

    // mixed extremes
    drain_results();
    load_timing('0, TICK_MAX, 17'd1, TICK_MAX - 17'd1, '0, TICK_MAX);
    random_ops(30);

    drain_results();
    load_random_timing();
    random_ops(30);

    drain_results();
    if (fail_count == 0 && outstanding == 0) begin
      $display("char_lcd_write_sequencer: match");
    end else begin
      $display("char_lcd_write_sequencer: mismatch");
    end
    $finish;
  end

endmodule
